FILE: design/lmh_pkg.sv
// shared types and constants of the landmark hasher
package lmh_pkg;

	// command codes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_ANCHOR = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_TARGET_START   = 2'd0;
	localparam logic [1:0] REG_TARGET_SPAN    = 2'd1;
	localparam logic [1:0] REG_FREQ_HALF_SPAN = 2'd2;
	localparam logic [1:0] REG_ZONE_POINTS    = 2'd3;

	// configuration reset values
	localparam logic [15:0] TARGET_START_RST   = 16'd1000;
	localparam logic [15:0] TARGET_SPAN_RST    = 16'd20000;
	localparam logic [16:0] FREQ_HALF_SPAN_RST = 17'd2500;
	localparam logic [3:0]  ZONE_POINTS_RST    = 4'd5;

	// field widths
	localparam int TIME_W = 24;
	localparam int FREQ_W = 18;
	localparam int AMP_W  = 16;
	localparam int HASH_W = 40;
	localparam int HF_W   = 14;
	localparam int DT_W   = 12;
	localparam int PEAK_W = TIME_W + FREQ_W + AMP_W;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] ptime;
		logic [FREQ_W-1:0] pfreq;
		logic [AMP_W-1:0]  pamp;
	} cmd_t;

	typedef struct packed {
		logic [15:0] start_delay;
		logic [15:0] target_span;
		logic [16:0] freq_half_span;
		logic [3:0]  zone_points;
	} cfg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ANC_RD,
		B_ANC_LAT,
		B_SCAN,
		B_PICK,
		B_SEEN,
		B_EMIT
	} back_state_t;

endpackage

FILE: design/lmh_ram.sv
// generic single-port ram with registered read
module lmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: design/lmh_front.sv
// front end: accepts items, drops unused codes, two-entry command queue
module lmh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          opcode,
	input  logic [23:0]         peak_time,
	input  logic [17:0]         peak_freq,
	input  logic [15:0]         peak_amp,
	output logic                cmd_valid,
	output lmh_pkg::cmd_t       cmd,
	input  logic                cmd_take
);

	lmh_pkg::cmd_t slot_q [2];
	logic          head_q;
	logic [1:0]    cnt_q;
	logic          enq;
	logic          deq;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[head_q];
	assign enq       = push && !full && (opcode != lmh_pkg::OP_UNUSED);
	assign deq       = cmd_take && cmd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[head_q ^ (cnt_q == 2'd1)] <= '{op: opcode, ptime: peak_time,
				pfreq: peak_freq, pamp: peak_amp};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (deq) begin
				head_q <= ~head_q;
			end
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

endmodule

FILE: design/lmh_back.sv
// back end: peak store, anchor scan with top-k selection, dedup and result buffer
module lmh_back #(
	parameter int MAX_PEAKS       = 1024,
	parameter int MAX_ZONE_POINTS = 8,
	parameter int SEEN_DEPTH      = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmh_pkg::cfg_t       cfg,
	input  logic                cmd_valid,
	input  lmh_pkg::cmd_t       cmd,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output logic [39:0]         hash_word,
	output logic [23:0]         anchor_time,
	output logic                hash_valid,
	output logic                last,
	output logic                all_done,
	output logic                seen_overflow,
	output logic                peak_overflow
);

	localparam int PT_W  = $clog2(MAX_PEAKS + 1);
	localparam int AW    = $clog2(MAX_PEAKS);
	localparam int ST_W  = $clog2(SEEN_DEPTH + 1);
	localparam int SAW   = $clog2(SEEN_DEPTH);
	localparam int KW    = $clog2(MAX_ZONE_POINTS + 1);
	localparam int CW    = $clog2(MAX_ZONE_POINTS + 2);
	localparam int IW    = (MAX_ZONE_POINTS > 1) ? $clog2(MAX_ZONE_POINTS) : 1;
	localparam int TW    = lmh_pkg::TIME_W;
	localparam int FW    = lmh_pkg::FREQ_W;
	localparam int MW    = lmh_pkg::AMP_W;

	lmh_pkg::back_state_t state_q, state_nx;

	// global state
	logic [PT_W-1:0]  pt_q, an_q, lim_q, ic_q;
	logic [2:0]       rem_q;
	logic [ST_W-1:0]  st_q, sc_q;
	logic [1:0]       flags_q;

	// anchor context
	logic [TW-1:0]    at_q;
	logic [FW-1:0]    af_q;
	logic [TW+1:0]    tmin_q, tmax_q;
	logic signed [FW+1:0] fmin_q;
	logic [FW:0]      fmax_q;
	logic             done_q, none_q, sel_best_q, found_q;
	logic [KW-1:0]    k_q, nbest_q, npick_q, pj_q, nres_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic [lmh_pkg::HASH_W-1:0] hash_q;

	// scan pipeline
	logic             v_s1, v_s2, hit_s2, rd_s1;
	logic [TW-1:0]    time_s2;
	logic [FW-1:0]    freq_s2;
	logic [MW-1:0]    amp_s2;

	// selection lanes and result buffer
	logic [TW-1:0]    best_t_q [MAX_ZONE_POINTS];
	logic [FW-1:0]    best_f_q [MAX_ZONE_POINTS];
	logic [MW-1:0]    best_a_q [MAX_ZONE_POINTS];
	logic [TW-1:0]    first_t_q [MAX_ZONE_POINTS];
	logic [FW-1:0]    first_f_q [MAX_ZONE_POINTS];
	logic [lmh_pkg::HASH_W-1:0] res_hash_q [MAX_ZONE_POINTS];

	// memories
	logic                                    pk_we;
	logic [AW-1:0]                           pk_addr;
	logic [lmh_pkg::PEAK_W-1:0]              pk_wdata, pk_rdata;
	logic                                    sn_we;
	logic [SAW-1:0]                          sn_addr;
	logic [39:0]                             sn_rdata;

	logic [TW-1:0]    rd_time;
	logic [FW-1:0]    rd_freq;
	logic [MW-1:0]    rd_amp;
	logic             hit_c;
	logic             issue_scan, scan_end, issue_seen, seen_fin;
	logic             ge [MAX_ZONE_POINTS];
	logic             prev_ge [MAX_ZONE_POINTS];
	logic             ins_ok;
	logic [KW-1:0]    k_c, ocnt;
	logic [TW-1:0]    pick_t;
	logic [FW-1:0]    pick_f;
	logic [TW-1:0]    dt_full;

	lmh_ram #(.WIDTH(lmh_pkg::PEAK_W), .DEPTH(MAX_PEAKS)) u_peak_ram (
		.clk(clk), .we(pk_we), .addr(pk_addr), .wdata(pk_wdata), .rdata(pk_rdata)
	);

	lmh_ram #(.WIDTH(40), .DEPTH(SEEN_DEPTH)) u_seen_ram (
		.clk(clk), .we(sn_we), .addr(sn_addr), .wdata(hash_q), .rdata(sn_rdata)
	);

	assign {rd_time, rd_freq, rd_amp} = pk_rdata;

	// window test on the peak coming out of the store
	assign hit_c = ({2'b0, rd_time} >= tmin_q) && ({2'b0, rd_time} <= tmax_q) &&
		($signed({2'b0, rd_freq}) >= fmin_q) && ({1'b0, rd_freq} <= fmax_q);

	// zone size clamp
	always_comb begin
		if (cfg.zone_points == 4'd0) begin
			k_c = KW'(1);
		end else if (32'(cfg.zone_points) > 32'(MAX_ZONE_POINTS)) begin
			k_c = KW'(MAX_ZONE_POINTS);
		end else begin
			k_c = KW'(cfg.zone_points);
		end
	end

	// strongest-first insertion lanes
	always_comb begin
		for (int j = 0; j < MAX_ZONE_POINTS; j++) begin
			ge[j] = (KW'(j) < nbest_q) && (best_a_q[j] >= amp_s2);
		end
		prev_ge[0] = 1'b1;
		for (int j = 1; j < MAX_ZONE_POINTS; j++) begin
			prev_ge[j] = ge[j-1];
		end
		ins_ok = (nbest_q < k_q) || !ge[IW'(k_q - KW'(1))];
	end

	// phase controls
	assign issue_scan = (state_q == lmh_pkg::B_SCAN) && (ic_q < pt_q);
	assign scan_end   = (state_q == lmh_pkg::B_SCAN) && !(ic_q < pt_q) && !v_s1 && !v_s2;
	assign issue_seen = (state_q == lmh_pkg::B_SEEN) && (sc_q < st_q);
	assign seen_fin   = (state_q == lmh_pkg::B_SEEN) && !(sc_q < st_q) && !rd_s1;

	// hash of the current pick
	assign pick_t  = sel_best_q ? best_t_q[pj_q[IW-1:0]] : first_t_q[pj_q[IW-1:0]];
	assign pick_f  = sel_best_q ? best_f_q[pj_q[IW-1:0]] : first_f_q[pj_q[IW-1:0]];
	assign dt_full = pick_t - at_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lmh_pkg::B_IDLE: begin
				if (cmd_valid && cmd.op == lmh_pkg::OP_ANCHOR) begin
					state_nx = (an_q >= lim_q) ? lmh_pkg::B_EMIT : lmh_pkg::B_ANC_RD;
				end
			end
			lmh_pkg::B_ANC_RD:  state_nx = lmh_pkg::B_ANC_LAT;
			lmh_pkg::B_ANC_LAT: state_nx = lmh_pkg::B_SCAN;
			lmh_pkg::B_SCAN: begin
				if (scan_end) begin
					state_nx = lmh_pkg::B_PICK;
				end
			end
			lmh_pkg::B_PICK: begin
				state_nx = (pj_q < npick_q) ? lmh_pkg::B_SEEN : lmh_pkg::B_EMIT;
			end
			lmh_pkg::B_SEEN: begin
				if (seen_fin) begin
					state_nx = lmh_pkg::B_PICK;
				end
			end
			lmh_pkg::B_EMIT: begin
				if (pop && last) begin
					state_nx = lmh_pkg::B_IDLE;
				end
			end
			default: state_nx = lmh_pkg::B_IDLE;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		cmd_take = (state_q == lmh_pkg::B_IDLE);
		pk_we    = 1'b0;
		pk_addr  = ic_q[AW-1:0];
		pk_wdata = {cmd.ptime, cmd.pfreq, cmd.pamp};
		sn_we    = 1'b0;
		sn_addr  = sc_q[SAW-1:0];
		case (state_q)
			lmh_pkg::B_IDLE: begin
				pk_addr = pt_q[AW-1:0];
				pk_we   = cmd_valid && (cmd.op == lmh_pkg::OP_LOAD) &&
					(32'(pt_q) < 32'(MAX_PEAKS));
			end
			lmh_pkg::B_ANC_RD: pk_addr = an_q[AW-1:0];
			lmh_pkg::B_SEEN: begin
				if (seen_fin) begin
					sn_addr = st_q[SAW-1:0];
					sn_we   = !found_q && (32'(st_q) < 32'(SEEN_DEPTH));
				end
			end
			default: ;
		endcase
	end

	// result port
	assign ocnt          = none_q ? KW'(1) : nres_q;
	assign empty         = (state_q != lmh_pkg::B_EMIT);
	assign hash_valid    = !none_q;
	assign hash_word     = none_q ? 40'd0 : res_hash_q[rp_q[IW-1:0]];
	assign anchor_time   = at_q;
	assign last          = (rp_q == ocnt - KW'(1));
	assign all_done      = done_q;
	assign seen_overflow = flags_q[0];
	assign peak_overflow = flags_q[1];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmh_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q    <= '0;
			an_q    <= '0;
			lim_q   <= '0;
			rem_q   <= '0;
			st_q    <= '0;
			flags_q <= '0;
			ic_q    <= '0;
			sc_q    <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			hit_s2  <= 1'b0;
			rd_s1   <= 1'b0;
			found_q <= 1'b0;
			nbest_q <= '0;
			cnt_q   <= '0;
			pj_q    <= '0;
			nres_q  <= '0;
			rp_q    <= '0;
			none_q  <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= '0;
			npick_q <= '0;
			sel_best_q <= 1'b0;
		end else begin
			v_s1  <= issue_scan;
			v_s2  <= v_s1;
			hit_s2 <= v_s1 && hit_c;
			rd_s1 <= issue_seen;
			case (state_q)
				lmh_pkg::B_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							lmh_pkg::OP_CLEAR: begin
								pt_q    <= '0;
								an_q    <= '0;
								lim_q   <= '0;
								rem_q   <= '0;
								st_q    <= '0;
								flags_q <= '0;
							end
							lmh_pkg::OP_LOAD: begin
								if (32'(pt_q) < 32'(MAX_PEAKS)) begin
									// track floor(4 * count / 5) as count grows
									pt_q <= pt_q + PT_W'(1);
									if (rem_q != 3'd0) begin
										lim_q <= lim_q + PT_W'(1);
										rem_q <= rem_q - 3'd1;
									end else begin
										rem_q <= 3'd4;
									end
								end else begin
									flags_q[1] <= 1'b1;
								end
							end
							lmh_pkg::OP_ANCHOR: begin
								if (an_q >= lim_q) begin
									none_q <= 1'b1;
									done_q <= 1'b1;
									rp_q   <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				lmh_pkg::B_ANC_LAT: begin
					an_q    <= an_q + PT_W'(1);
					done_q  <= (an_q + PT_W'(1)) >= lim_q;
					k_q     <= k_c;
					ic_q    <= '0;
					cnt_q   <= '0;
					nbest_q <= '0;
				end
				lmh_pkg::B_SCAN: begin
					if (issue_scan) begin
						ic_q <= ic_q + PT_W'(1);
					end
					if (hit_s2) begin
						if (cnt_q <= CW'(k_q)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (ins_ok && nbest_q < k_q) begin
							nbest_q <= nbest_q + KW'(1);
						end
					end
					if (scan_end) begin
						sel_best_q <= cnt_q > CW'(k_q);
						npick_q    <= (cnt_q > CW'(k_q)) ? nbest_q : KW'(cnt_q);
						pj_q       <= '0;
						nres_q     <= '0;
					end
				end
				lmh_pkg::B_PICK: begin
					sc_q    <= '0;
					found_q <= 1'b0;
					if (!(pj_q < npick_q)) begin
						none_q <= (nres_q == '0);
						rp_q   <= '0;
					end
				end
				lmh_pkg::B_SEEN: begin
					if (issue_seen) begin
						sc_q <= sc_q + ST_W'(1);
					end
					if (rd_s1 && sn_rdata == hash_q) begin
						found_q <= 1'b1;
					end
					if (seen_fin) begin
						pj_q <= pj_q + KW'(1);
						if (!found_q) begin
							nres_q <= nres_q + KW'(1);
							if (32'(st_q) < 32'(SEEN_DEPTH)) begin
								st_q <= st_q + ST_W'(1);
							end else begin
								flags_q[0] <= 1'b1;
							end
						end
					end
				end
				lmh_pkg::B_EMIT: begin
					if (pop) begin
						rp_q <= rp_q + KW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// anchor context and scan payload
	always_ff @(posedge clk) begin
		time_s2 <= rd_time;
		freq_s2 <= rd_freq;
		amp_s2  <= rd_amp;
		if (state_q == lmh_pkg::B_IDLE && cmd_valid && cmd.op == lmh_pkg::OP_ANCHOR) begin
			at_q <= '0;
		end
		if (state_q == lmh_pkg::B_ANC_LAT) begin
			at_q   <= rd_time;
			af_q   <= rd_freq;
			tmin_q <= (TW+2)'(rd_time) + (TW+2)'(cfg.start_delay);
			tmax_q <= (TW+2)'(rd_time) + (TW+2)'(cfg.start_delay) +
				(TW+2)'(cfg.target_span);
			fmin_q <= $signed({2'b0, rd_freq}) - $signed({3'b0, cfg.freq_half_span});
			fmax_q <= (FW+1)'(rd_freq) + (FW+1)'(cfg.freq_half_span);
		end
		if (state_q == lmh_pkg::B_PICK && pj_q < npick_q) begin
			hash_q <= {af_q[lmh_pkg::HF_W-1:0], pick_f[lmh_pkg::HF_W-1:0],
				dt_full[lmh_pkg::DT_W-1:0]};
		end
		if (seen_fin && !found_q) begin
			res_hash_q[nres_q[IW-1:0]] <= hash_q;
		end
	end

	// selection lanes: store order list and strongest-first list
	always_ff @(posedge clk) begin
		if (state_q == lmh_pkg::B_SCAN && hit_s2) begin
			if (cnt_q < CW'(k_q)) begin
				first_t_q[cnt_q[IW-1:0]] <= time_s2;
				first_f_q[cnt_q[IW-1:0]] <= freq_s2;
			end
			if (ins_ok) begin
				for (int j = 0; j < MAX_ZONE_POINTS; j++) begin
					if (!ge[j]) begin
						if (prev_ge[j]) begin
							best_t_q[j] <= time_s2;
							best_f_q[j] <= freq_s2;
							best_a_q[j] <= amp_s2;
						end else if (j > 0) begin
							best_t_q[j] <= best_t_q[(j > 0) ? j - 1 : 0];
							best_f_q[j] <= best_f_q[(j > 0) ? j - 1 : 0];
							best_a_q[j] <= best_a_q[(j > 0) ? j - 1 : 0];
						end
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_rp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmh_pkg::B_EMIT) |-> (rp_q < ocnt))
		else $error("result read index past buffered results");
	a_nbest_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmh_pkg::B_SCAN) |-> (nbest_q <= k_q))
		else $error("strongest list grew beyond zone size");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(st_q) <= 32'(SEEN_DEPTH))
		else $error("seen count beyond table depth");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last) |=> empty)
		else $error("results continue after last transfer");
	a_anchor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		an_q <= lim_q || $past(an_q) > $past(lim_q) || (an_q == $past(an_q)))
		else $error("anchor index passed the anchor limit");
`endif

endmodule

FILE: design/topk_landmark_hasher_dedup.sv
// top level: configuration registers, front queue and back end of the landmark hasher
//
// Clear and load transfers are taken from the command queue while the back end is
// idle. An anchor step reads the anchor from the single-port peak store, scans the
// whole store, then scans the seen-hash table linearly once per kept target, closes
// the step, and then releases one result per pop; the peak store scan and the seen
// table scan set the length of the step. An anchor step with no anchor left goes
// straight to its single result. A two-entry command queue keeps taking input
// transfers while results wait, until it holds two. All results of an anchor step
// are buffered and released together once the step's dedup work is done, so
// their flags are final.
module topk_landmark_hasher_dedup #(
	parameter int MAX_PEAKS       = 1024,
	parameter int MAX_ZONE_POINTS = 8,
	parameter int SEEN_DEPTH      = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [23:0] peak_time,
	input  logic [17:0] peak_freq,
	input  logic [15:0] peak_amp,
	output logic        empty,
	input  logic        pop,
	output logic [39:0] hash_word,
	output logic [23:0] anchor_time,
	output logic        hash_valid,
	output logic        last,
	output logic        all_done,
	output logic        seen_overflow,
	output logic        peak_overflow
);

	lmh_pkg::cfg_t cfg_q;
	lmh_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_take;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delay    <= lmh_pkg::TARGET_START_RST;
			cfg_q.target_span    <= lmh_pkg::TARGET_SPAN_RST;
			cfg_q.freq_half_span <= lmh_pkg::FREQ_HALF_SPAN_RST;
			cfg_q.zone_points    <= lmh_pkg::ZONE_POINTS_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				lmh_pkg::REG_TARGET_START:   cfg_q.start_delay    <= pwdata[15:0];
				lmh_pkg::REG_TARGET_SPAN:    cfg_q.target_span    <= pwdata[15:0];
				lmh_pkg::REG_FREQ_HALF_SPAN: cfg_q.freq_half_span <= pwdata[16:0];
				lmh_pkg::REG_ZONE_POINTS:    cfg_q.zone_points    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			lmh_pkg::REG_TARGET_START:   prdata = {16'd0, cfg_q.start_delay};
			lmh_pkg::REG_TARGET_SPAN:    prdata = {16'd0, cfg_q.target_span};
			lmh_pkg::REG_FREQ_HALF_SPAN: prdata = {15'd0, cfg_q.freq_half_span};
			lmh_pkg::REG_ZONE_POINTS:    prdata = {28'd0, cfg_q.zone_points};
			default:                     prdata = 32'd0;
		endcase
	end

	lmh_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.peak_time(peak_time), .peak_freq(peak_freq), .peak_amp(peak_amp),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	lmh_back #(
		.MAX_PEAKS(MAX_PEAKS), .MAX_ZONE_POINTS(MAX_ZONE_POINTS), .SEEN_DEPTH(SEEN_DEPTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .hash_word(hash_word),
		.anchor_time(anchor_time), .hash_valid(hash_valid), .last(last),
		.all_done(all_done), .seen_overflow(seen_overflow), .peak_overflow(peak_overflow)
	);

endmodule
